@@ hdl/wfd_pkg.sv @@
// Shared types, constants and the quarter-wave sine function for the
// wow/flutter modulated delay. No dependencies.
`timescale 1ns / 1ps

package wfd_pkg;

    localparam int SAMPLE_W = 24;
    localparam int CFG_W    = 32;
    localparam int DEPTH_W  = 16;
    localparam int SINE_W   = 15;
    localparam int FRAC_W   = 30;
    localparam int MOD_W    = 34;

    // serial multiplier geometry: signed multiplicand, unsigned multiplier in nibbles
    localparam int DIGIT_W    = 4;
    localparam int MPLIER_W   = 32;
    localparam int NUM_DIGITS = MPLIER_W / DIGIT_W;
    localparam int MCAND_W    = 25;
    localparam int ACC_W      = MCAND_W + 1;
    localparam int PROD_W     = ACC_W + MPLIER_W;

    // odd sine polynomial, Q30
    localparam logic [63:0] POLY_A1 = 64'd1686629713;
    localparam logic [63:0] POLY_A3 = 64'd693598669;
    localparam logic [63:0] POLY_A5 = 64'd85569306;
    localparam logic [63:0] POLY_A7 = 64'd5026995;
    localparam logic [63:0] POLY_A9 = 64'd172272;
    localparam logic [63:0] SINE_PEAK = 64'd32767;

    typedef enum logic [1:0] {
        CFG_WOW_INC,
        CFG_FLUTTER_INC,
        CFG_WOW_DEPTH,
        CFG_FLUTTER_DEPTH
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_ROM,
        ST_START,
        ST_MUL,
        ST_DELAY,
        ST_ADDR,
        ST_FETCH,
        ST_INTERP,
        ST_ROUND,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        PASS_WOW,
        PASS_FLUTTER,
        PASS_INTERP
    } pass_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

    function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] prod;
        prod = a * b;
        return prod >> 30;
    endfunction

    // x is the angle as a Q30 fraction of a quarter turn
    function automatic logic [SINE_W-1:0] sine_entry(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] p;
        logic [63:0] v;
        x2 = mul_q30(x, x);
        p  = POLY_A7 - mul_q30(x2, POLY_A9);
        p  = POLY_A5 - mul_q30(x2, p);
        p  = POLY_A3 - mul_q30(x2, p);
        p  = POLY_A1 - mul_q30(x2, p);
        p  = mul_q30(x, p);
        v  = (p * SINE_PEAK + (64'd1 << 29)) >> 30;
        if (v > SINE_PEAK)
        begin
            v = SINE_PEAK;
        end
        return v[SINE_W-1:0];
    endfunction

endpackage

@@ hdl/wfd_serial_mul.sv @@
// Nibble-serial signed x unsigned multiplier, one digit per cycle.
// Depends on wfd_pkg.
`timescale 1ns / 1ps

module wfd_serial_mul
    import wfd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [MCAND_W-1:0] multiplicand,
    input  logic [MPLIER_W-1:0]       multiplier,
    output mul_stat_t                 status,
    output logic signed [PROD_W-1:0]  product
);

    localparam int CNT_W  = $clog2(NUM_DIGITS);
    localparam int STEP_W = ACC_W + DIGIT_W;

    logic signed [MCAND_W-1:0] mcand_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic [MPLIER_W-1:0]       shift_reg;
    logic [MPLIER_W-1:0]       shift_next;
    logic [CNT_W-1:0]          count_reg;
    logic                      busy_reg;
    logic                      done_reg;

    logic signed [STEP_W-1:0]  mcand_ext;
    logic signed [STEP_W-1:0]  digit_ext;
    logic signed [STEP_W-1:0]  partial;
    logic signed [STEP_W-1:0]  step_sum;

    assign mcand_ext = STEP_W'(mcand_reg);
    assign digit_ext = $signed({(STEP_W - DIGIT_W)'(0), shift_reg[DIGIT_W-1:0]});
    assign partial   = mcand_ext * digit_ext;
    assign step_sum  = STEP_W'(acc_reg) + partial;

    // low nibble of each step retires into the top of the multiplier shift register
    assign acc_next   = step_sum[STEP_W-1:DIGIT_W];
    assign shift_next = {step_sum[DIGIT_W-1:0], shift_reg[MPLIER_W-1:DIGIT_W]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= CNT_W'(NUM_DIGITS - 1);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg <= multiplicand;
            acc_reg   <= '0;
            shift_reg <= multiplier;
        end
        else if (busy_reg)
        begin
            acc_reg   <= acc_next;
            shift_reg <= shift_next;
        end
    end

    assign product     = {acc_reg, shift_reg};
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

@@ hdl/wow_flutter_modulated_delay_unit.sv @@
// Top level of the wow/flutter modulated fractional delay (tape vibrato).
// Depends on wfd_pkg and wfd_serial_mul.
`timescale 1ns / 1ps

// One signed 24-bit sample in, one delayed sample out. A sample that is
// processed runs from acceptance to a valid result, and the next sample is
// taken once that result has moved into the output register, so the block
// takes no new sample before it is through with the last. The pace is set by
// the single nibble-serial multiplier, which forms the wow product, the
// flutter product and the interpolation product one after the other, with
// sequencing states between them. With both depths at zero a sample passes
// through and no state changes. The delay line is a memory with two registered
// read ports; slots not written since reset read as zero through a fill count,
// so there is no clearing pass. The output register holds a finished result
// under stall while the next sample is already being accepted and processed.
module wow_flutter_modulated_delay_unit
    import wfd_pkg::*;
#(
    parameter int DELAY_DEPTH     = 16,
    parameter int CENTER_DELAY    = 4,
    parameter int SINE_TABLE_SIZE = 256
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [$bits(cfg_index_t)-1:0]    cfg_index,
    input  logic [CFG_W-1:0]                 cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [SAMPLE_W-1:0]       sample_in,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [SAMPLE_W-1:0]       sample_out
);

    localparam int AW         = $clog2(DELAY_DEPTH);
    localparam int FW         = $clog2(DELAY_DEPTH + 1);
    localparam int IW         = $clog2(SINE_TABLE_SIZE);
    localparam int QuarterLen = SINE_TABLE_SIZE / 4;
    localparam int QW         = $clog2(QuarterLen + 1);
    localparam int D_W        = AW + MOD_W;
    localparam int Y_W        = PROD_W - FRAC_W;

    localparam logic signed [D_W-1:0] D_CENTER = D_W'(CENTER_DELAY) <<< FRAC_W;
    localparam logic signed [D_W-1:0] D_MIN    = D_W'(1) <<< FRAC_W;
    localparam logic signed [D_W-1:0] D_MAX    = D_W'(DELAY_DEPTH - 1) <<< FRAC_W;
    localparam logic signed [Y_W-1:0] Y_MAX    = Y_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [Y_W-1:0] Y_MIN    = Y_W'(-(1 << (SAMPLE_W - 1)));

    // configuration
    logic [CFG_W-1:0]   wow_inc_reg;
    logic [CFG_W-1:0]   flutter_inc_reg;
    logic [DEPTH_W-1:0] wow_depth_reg;
    logic [DEPTH_W-1:0] flutter_depth_reg;

    // control
    state_t             state_reg;
    state_t             state_next;
    pass_t              pass_reg;
    pass_t              pass_next;
    logic               in_accept;
    logic               bypass;
    logic               mul_start;
    logic               line_write;
    logic               out_load;
    logic               out_valid_reg;

    // state of the effect
    logic [31:0]        wow_phase_reg;
    logic [31:0]        flutter_phase_reg;
    logic [AW-1:0]      wp_reg;
    logic [FW-1:0]      fill_reg;
    logic signed [SAMPLE_W-1:0] line_mem [DELAY_DEPTH];

    // datapath
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] result_reg;
    logic signed [SAMPLE_W-1:0] sample_out_reg;
    logic [QW-1:0]              rom_addr_reg;
    logic                       quad_neg_reg;
    logic                       quad_zero_reg;
    logic [SINE_W-1:0]          rom_val_reg;
    logic signed [MOD_W-1:0]    mod_acc_reg;
    logic signed [PROD_W-1:0]   interp_reg;
    logic [AW-1:0]              delay_int_reg;
    logic [FRAC_W-1:0]          frac_reg;
    logic [AW-1:0]              rd1_reg;
    logic [AW-1:0]              rd2_reg;
    logic signed [SAMPLE_W-1:0] tap_a_reg;
    logic signed [SAMPLE_W-1:0] tap_b_reg;
    logic                       a_valid_reg;
    logic                       b_valid_reg;

    // sine lookup
    logic [SINE_W-1:0]  quarter_rom [QuarterLen + 1];
    logic [31:0]        phase_sel;
    logic [IW+31:0]     phase_scaled;
    logic [IW-1:0]      sine_idx;
    logic [IW:0]        idx_ext;
    logic [IW:0]        quad_addr;
    logic               quad_neg;
    logic               quad_zero;

    // multiplier operands and result
    logic signed [MCAND_W-1:0] sine_mag;
    logic signed [MCAND_W-1:0] sine_signed;
    logic signed [MCAND_W-1:0] tap_diff;
    logic signed [MCAND_W-1:0] mul_mcand;
    logic [MPLIER_W-1:0]       mul_mplier;
    logic [MPLIER_W-1:0]       depth_sel;
    mul_stat_t                 mul_stat;
    logic signed [PROD_W-1:0]  mul_product;

    // delay and read addresses
    logic signed [D_W-1:0]     d_raw;
    logic signed [D_W-1:0]     d_clamp;
    logic [AW:0]               addr_diff;
    logic [AW:0]               addr_wrap;
    logic [AW-1:0]             rd1_addr;
    logic [AW-1:0]             rd2_addr;

    // interpolation output
    logic signed [SAMPLE_W-1:0] tap_a_eff;
    logic signed [SAMPLE_W-1:0] tap_b_eff;
    logic signed [PROD_W-1:0]   round_sum;
    logic signed [Y_W-1:0]      y_full;
    logic signed [SAMPLE_W-1:0] y_sat;

    // quarter-wave table, built at elaboration
    for (genvar k = 0; k <= QuarterLen; k++)
    begin : g_rom
        localparam logic [63:0] ANGLE = (64'(k) << 30) / QuarterLen;
        assign quarter_rom[k] = sine_entry(ANGLE);
    end

    assign bypass   = (wow_depth_reg == '0) && (flutter_depth_reg == '0);
    assign in_stall = (state_reg != ST_IDLE);

    // ---------------- sine index and quadrant mapping ----------------
    assign phase_sel    = (pass_reg == PASS_WOW) ? wow_phase_reg : flutter_phase_reg;
    assign phase_scaled = (IW + 32)'(phase_sel) * (IW + 32)'(SINE_TABLE_SIZE);
    assign sine_idx     = phase_scaled[IW+31:32];
    assign idx_ext      = {1'b0, sine_idx};

    always_comb
    begin
        quad_addr = '0;
        quad_neg  = 1'b0;
        quad_zero = 1'b0;
        if (idx_ext < (IW + 1)'(QuarterLen))
        begin
            quad_addr = idx_ext;
        end
        else if (idx_ext < (IW + 1)'(2 * QuarterLen))
        begin
            quad_addr = (IW + 1)'(2 * QuarterLen) - idx_ext;
        end
        else if (idx_ext < (IW + 1)'(3 * QuarterLen))
        begin
            quad_addr = idx_ext - (IW + 1)'(2 * QuarterLen);
            quad_neg  = 1'b1;
        end
        else if (idx_ext <= (IW + 1)'(4 * QuarterLen))
        begin
            quad_addr = (IW + 1)'(4 * QuarterLen) - idx_ext;
            quad_neg  = 1'b1;
        end
        else
        begin
            // table size not a multiple of four: top indexes read as zero
            quad_zero = 1'b1;
        end
    end

    // ---------------- multiplier operands ----------------
    assign sine_mag    = $signed(MCAND_W'(rom_val_reg));
    assign sine_signed = quad_zero_reg ? '0 : (quad_neg_reg ? -sine_mag : sine_mag);
    assign depth_sel   = (pass_reg == PASS_WOW) ? MPLIER_W'(wow_depth_reg)
                                                : MPLIER_W'(flutter_depth_reg);

    assign tap_a_eff = a_valid_reg ? tap_a_reg : '0;
    assign tap_b_eff = b_valid_reg ? tap_b_reg : '0;
    // a*(1-f) + b*f is a + (b-a)*f
    assign tap_diff  = MCAND_W'(tap_b_eff) - MCAND_W'(tap_a_eff);

    assign mul_mcand  = (state_reg == ST_INTERP) ? tap_diff : sine_signed;
    assign mul_mplier = (state_reg == ST_INTERP) ? MPLIER_W'(frac_reg) : depth_sel;

    wfd_serial_mul u_mul
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mul_start),
        .multiplicand (mul_mcand),
        .multiplier   (mul_mplier),
        .status       (mul_stat),
        .product      (mul_product)
    );

    // ---------------- delay and addresses ----------------
    assign d_raw = D_CENTER - D_W'(mod_acc_reg);

    always_comb
    begin
        d_clamp = d_raw;
        if (d_raw < D_MIN)
        begin
            d_clamp = D_MIN;
        end
        else if (d_raw > D_MAX)
        begin
            d_clamp = D_MAX;
        end
    end

    assign addr_diff = {1'b0, wp_reg} - {1'b0, delay_int_reg};
    assign addr_wrap = addr_diff + (AW + 1)'(DELAY_DEPTH);
    assign rd1_addr  = addr_diff[AW] ? addr_wrap[AW-1:0] : addr_diff[AW-1:0];
    assign rd2_addr  = (rd1_addr == '0) ? AW'(DELAY_DEPTH - 1) : rd1_addr - 1'b1;

    // ---------------- rounding and saturation ----------------
    assign round_sum = (PROD_W'(tap_a_eff) <<< FRAC_W) + interp_reg
                     + (PROD_W'(1) <<< (FRAC_W - 1));
    assign y_full    = round_sum[PROD_W-1:FRAC_W];

    always_comb
    begin
        if (y_full > Y_MAX)
        begin
            y_sat = Y_MAX[SAMPLE_W-1:0];
        end
        else if (y_full < Y_MIN)
        begin
            y_sat = Y_MIN[SAMPLE_W-1:0];
        end
        else
        begin
            y_sat = y_full[SAMPLE_W-1:0];
        end
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        in_accept  = 1'b0;
        mul_start  = 1'b0;
        line_write = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    in_accept  = 1'b1;
                    pass_next  = PASS_WOW;
                    state_next = bypass ? ST_DONE : ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_ROM;
            end
            ST_ROM:
            begin
                state_next = ST_START;
            end
            ST_START:
            begin
                mul_start  = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (mul_stat.done)
                begin
                    case (pass_reg)
                        PASS_WOW:
                        begin
                            pass_next  = PASS_FLUTTER;
                            state_next = ST_LOOKUP;
                        end
                        PASS_FLUTTER:
                        begin
                            state_next = ST_DELAY;
                        end
                        default:
                        begin
                            state_next = ST_ROUND;
                        end
                    endcase
                end
            end
            ST_DELAY:
            begin
                state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                state_next = ST_INTERP;
            end
            ST_INTERP:
            begin
                // taps are already registered, so the new sample can go in now
                mul_start  = 1'b1;
                line_write = 1'b1;
                pass_next  = PASS_INTERP;
                state_next = ST_MUL;
            end
            ST_ROUND:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pass_reg  <= PASS_WOW;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
        end
    end

    // ---------------- configuration and effect state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wow_inc_reg       <= '0;
            flutter_inc_reg   <= '0;
            wow_depth_reg     <= '0;
            flutter_depth_reg <= '0;
            wow_phase_reg     <= '0;
            flutter_phase_reg <= '0;
            wp_reg            <= '0;
            fill_reg          <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_WOW_INC:       wow_inc_reg       <= cfg_data;
                    CFG_FLUTTER_INC:   flutter_inc_reg   <= cfg_data;
                    CFG_WOW_DEPTH:     wow_depth_reg     <= cfg_data[DEPTH_W-1:0];
                    CFG_FLUTTER_DEPTH: flutter_depth_reg <= cfg_data[DEPTH_W-1:0];
                    default:           ;
                endcase
            end

            if (in_accept && !bypass)
            begin
                wow_phase_reg     <= wow_phase_reg + wow_inc_reg;
                flutter_phase_reg <= flutter_phase_reg + flutter_inc_reg;
            end

            if (line_write)
            begin
                wp_reg <= (wp_reg == AW'(DELAY_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                if (fill_reg != FW'(DELAY_DEPTH))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- delay line memory ----------------
    always_ff @(posedge clk)
    begin
        if (line_write)
        begin
            line_mem[wp_reg] <= sample_reg;
        end
        if (state_reg == ST_FETCH)
        begin
            tap_a_reg   <= line_mem[rd1_reg];
            tap_b_reg   <= line_mem[rd2_reg];
            a_valid_reg <= (FW'(rd1_reg) < fill_reg);
            b_valid_reg <= (FW'(rd2_reg) < fill_reg);
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sample_reg <= sample_in;
            result_reg <= sample_in;
        end
        if (state_reg == ST_LOOKUP)
        begin
            rom_addr_reg  <= quad_addr[QW-1:0];
            quad_neg_reg  <= quad_neg;
            quad_zero_reg <= quad_zero;
        end
        if (state_reg == ST_ROM)
        begin
            rom_val_reg <= quarter_rom[rom_addr_reg];
        end
        if ((state_reg == ST_MUL) && mul_stat.done)
        begin
            case (pass_reg)
                PASS_WOW:     mod_acc_reg <= mul_product[MOD_W-1:0];
                PASS_FLUTTER: mod_acc_reg <= mod_acc_reg + mul_product[MOD_W-1:0];
                default:      interp_reg  <= mul_product;
            endcase
        end
        if (state_reg == ST_DELAY)
        begin
            delay_int_reg <= d_clamp[AW+FRAC_W-1:FRAC_W];
            frac_reg      <= d_clamp[FRAC_W-1:0];
        end
        if (state_reg == ST_ADDR)
        begin
            rd1_reg <= rd1_addr;
            rd2_reg <= rd2_addr;
        end
        if (state_reg == ST_ROUND)
        begin
            result_reg <= y_sat;
        end
        if (out_load)
        begin
            sample_out_reg <= result_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

    // ---------------- assertions ----------------
    // the integer tap never lands on the slot about to be written
    a_read_not_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH) |-> (rd1_reg != wp_reg))
        else $error("delay tap reads the write slot");

    a_delay_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADDR) |->
            ((delay_int_reg != '0) && (delay_int_reg <= AW'(DELAY_DEPTH - 1))))
        else $error("clamped delay out of range");

    // until the line has wrapped, the fill count tracks the write pointer
    a_fill_track: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == FW'(DELAY_DEPTH)) || (fill_reg == FW'(wp_reg)))
        else $error("fill count lost track of write pointer");

    a_mul_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_START) || (state_reg == ST_INTERP)) |=> mul_stat.busy)
        else $error("multiplier did not start");

    a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
        mul_stat.done |-> (state_reg == ST_MUL))
        else $error("multiplier finished outside the wait state");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result transaction raised outside the done state");

endmodule
